### hw/rtl/bpargb_pkg.sv
// Shared types, constants and helpers for the bitplane to ARGB converter.
`default_nettype none
package bpargb_pkg;

    localparam int PLANE_INPUTS        = 5;
    localparam int PIX_PER_GROUP       = 8;
    localparam int DEF_PALETTE_ENTRIES = 32;
    localparam int DEF_MAX_PLANES      = 5;

    localparam logic [31:0] ALPHA_OPAQUE = 32'hff000000;
    localparam logic [7:0]  NIBBLE_SCALE = 8'd17;

    typedef enum logic {
        OP_PAL_WRITE = 1'b0,
        OP_PIXELS    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_PLANE_COUNT = 2'd0,
        CFG_MASK_ENABLE = 2'd1,
        CFG_ROW_BYTES   = 2'd2,
        CFG_ROW_TOTAL   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  plane_count;
        logic        mask_enable;
        logic [15:0] row_bytes;
        logic [15:0] row_total;
    } t_cfg;

    // Palette access issued by the sequencer
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic zero;
        logic group_last;
        logic sprite_last;
    } t_pal_ctl;

    typedef struct packed {
        logic [31:0] argb;
        logic        group_last;
        logic        sprite_last;
    } t_pix;

    // 4-bit channels scaled by 17 to 8 bits, alpha forced opaque
    function automatic logic [31:0] widen_rgb(input logic [11:0] rgb);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = 8'(rgb[11:8]) * NIBBLE_SCALE;
        g = 8'(rgb[7:4]) * NIBBLE_SCALE;
        b = 8'(rgb[3:0]) * NIBBLE_SCALE;
        return ALPHA_OPAQUE | {8'h00, r, g, b};
    endfunction

endpackage
`default_nettype wire

### hw/rtl/bpargb_palette.sv
// Palette memory with per-entry valid bits and registered read.
`default_nettype none
module bpargb_palette #(
    parameter int PALETTE_ENTRIES = bpargb_pkg::DEF_PALETTE_ENTRIES,
    localparam int AW = $clog2(PALETTE_ENTRIES)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bpargb_pkg::t_pal_ctl i_ctl,
    input  wire logic [AW-1:0]        i_addr,
    input  wire logic [31:0]          i_wdata,
    output logic                      o_valid,
    output bpargb_pkg::t_pix          o_pix
);

    logic [31:0]                mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_vld;
    logic [31:0]                r_rdata;
    logic                       r_rd_v;
    logic                       r_hit;
    logic                       r_zero;
    logic                       r_glast;
    logic                       r_slast;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= mem[i_addr];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rd_v <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_addr] <= 1'b1;
            end
            r_rd_v <= i_ctl.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_hit   <= r_vld[i_addr];
            r_zero  <= i_ctl.zero;
            r_glast <= i_ctl.group_last;
            r_slast <= i_ctl.sprite_last;
        end
    end

    assign o_valid           = r_rd_v;
    assign o_pix.argb        = (r_zero || !r_hit) ? 32'h0 : r_rdata;
    assign o_pix.group_last  = r_glast;
    assign o_pix.sprite_last = r_slast;

endmodule
`default_nettype wire

### hw/rtl/bpargb_seq.sv
// Item register, pixel sequencer and sprite position counters.
`default_nettype none
module bpargb_seq #(
    parameter int PALETTE_ENTRIES = bpargb_pkg::DEF_PALETTE_ENTRIES,
    parameter int MAX_PLANES      = bpargb_pkg::DEF_MAX_PLANES,
    localparam int AW = $clog2(PALETTE_ENTRIES)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire bpargb_pkg::t_cfg       i_cfg,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_operation,
    input  wire logic [4:0]             i_palette_slot,
    input  wire logic [11:0]            i_palette_rgb,
    input  wire logic [bpargb_pkg::PLANE_INPUTS-1:0][7:0] i_plane_bytes,
    input  wire logic [7:0]             i_mask_byte,
    input  wire logic                   i_can_issue,
    output bpargb_pkg::t_pal_ctl        o_ctl,
    output logic [AW-1:0]               o_addr,
    output logic [31:0]                 o_wdata
);

    localparam int NPL = bpargb_pkg::PLANE_INPUTS;
    localparam int CW  = (AW > NPL) ? AW : NPL;
    localparam int PLANES_USED = (MAX_PLANES < NPL) ? MAX_PLANES : NPL;

    logic                  r_busy;
    bpargb_pkg::t_op       r_op;
    logic [4:0]            r_slot;
    logic [11:0]           r_rgb;
    logic [NPL-1:0][7:0]   r_planes;
    logic [7:0]            r_mask;
    logic [2:0]            r_k;
    logic                  r_final;
    logic [15:0]           r_col;
    logic [15:0]           r_row;

    logic [15:0]           n_col;
    logic [15:0]           n_row;

    logic [2:0]            w_bit;
    logic [2:0]            w_np;
    logic [NPL-1:0]        w_colour;
    logic [CW-1:0]         w_colour_ext;
    logic [CW-1:0]         w_slot_ext;
    logic                  w_in_range;
    logic                  w_slot_ok;
    logic                  w_shown;
    logic                  w_is_wr;
    logic                  w_is_rd;
    logic                  w_last_pix;
    logic                  w_done;
    logic                  w_accept;
    logic [15:0]           w_rb;
    logic [15:0]           w_rt;
    logic [16:0]           w_col_inc;
    logic [16:0]           w_row_inc;
    logic                  w_final;

    always_comb begin
        w_np = (i_cfg.plane_count == 3'd0) ? 3'd1 : i_cfg.plane_count;
        if (32'(w_np) > PLANES_USED) begin
            w_np = 3'(PLANES_USED);
        end
    end

    assign w_bit = 3'd7 - r_k;

    always_comb begin
        for (int p = 0; p < NPL; p++) begin
            w_colour[p] = (3'(p) < w_np) && r_planes[p][w_bit];
        end
    end

    assign w_colour_ext = CW'(w_colour);
    assign w_slot_ext   = CW'(r_slot);
    assign w_in_range   = 32'(w_colour) < PALETTE_ENTRIES;
    assign w_slot_ok    = 32'(r_slot) < PALETTE_ENTRIES;
    assign w_shown      = !i_cfg.mask_enable || r_mask[w_bit];

    assign w_is_wr    = r_busy && (r_op == bpargb_pkg::OP_PAL_WRITE);
    assign w_is_rd    = r_busy && (r_op == bpargb_pkg::OP_PIXELS) && i_can_issue;
    assign w_last_pix = r_k == 3'(bpargb_pkg::PIX_PER_GROUP - 1);
    assign w_done     = w_is_wr || (w_is_rd && w_last_pix);
    assign o_in_stall = r_busy && !w_done;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign o_ctl.wr_en       = w_is_wr && w_slot_ok;
    assign o_ctl.rd_en       = w_is_rd;
    assign o_ctl.zero        = !w_shown || !w_in_range;
    assign o_ctl.group_last  = w_last_pix;
    assign o_ctl.sprite_last = w_last_pix && r_final;
    assign o_addr  = w_is_wr ? w_slot_ext[AW-1:0] : w_colour_ext[AW-1:0];
    assign o_wdata = bpargb_pkg::widen_rgb(r_rgb);

    // position counters, advanced when a group is taken in
    assign w_rb      = (i_cfg.row_bytes == 16'd0) ? 16'd1 : i_cfg.row_bytes;
    assign w_rt      = (i_cfg.row_total == 16'd0) ? 16'd1 : i_cfg.row_total;
    assign w_col_inc = {1'b0, r_col} + 17'd1;
    assign w_row_inc = {1'b0, r_row} + 17'd1;
    assign w_final   = (w_col_inc >= {1'b0, w_rb}) && (w_row_inc >= {1'b0, w_rt});

    always_comb begin
        n_col = w_col_inc[15:0];
        n_row = r_row;
        if (n_col >= w_rb) begin
            n_col = 16'd0;
            n_row = w_row_inc[15:0];
            if (n_row >= w_rt) begin
                n_row = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 3'd0;
            r_col  <= 16'd0;
            r_row  <= 16'd0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_k    <= 3'd0;
                if (i_operation == bpargb_pkg::OP_PIXELS) begin
                    r_col <= n_col;
                    r_row <= n_row;
                end
            end else if (w_done) begin
                r_busy <= 1'b0;
            end else if (w_is_rd) begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= bpargb_pkg::t_op'(i_operation);
            r_slot   <= i_palette_slot;
            r_rgb    <= i_palette_rgb;
            r_planes <= i_plane_bytes;
            r_mask   <= i_mask_byte;
            r_final  <= w_final;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/bpargb_outq.sv
// Two-entry output queue between the palette read and the result channel.
`default_nettype none
module bpargb_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bpargb_pkg::t_pix i_pix,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output bpargb_pkg::t_pix      o_pix,
    output logic [1:0]            o_count
);

    bpargb_pkg::t_pix r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_pop;

    assign o_valid = r_cnt != 2'd0;
    assign o_pix   = r_q[r_rp];
    assign o_count = r_cnt;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
        end
    end

endmodule
`default_nettype wire

### hw/rtl/bitplane_to_argb_pixel_converter_unit.sv
// Top level of the bitplane to ARGB pixel converter.
// A pixel-group item issues one palette read per pixel and yields 8 results,
// one per cycle while the output queue has room; a palette-write item yields
// nothing. The single palette read port sets that rate. A new item is taken in
// the cycle the previous one issues its last access, so groups stream back to
// back. Pixels pass the item register, palette read register and output queue.
// The palette reads as zero after reset through per-entry valid bits; there is
// no clearing pass. Register writes are expected only while the block is idle.
`default_nettype none
module bitplane_to_argb_pixel_converter_unit #(
    parameter int PALETTE_ENTRIES = bpargb_pkg::DEF_PALETTE_ENTRIES,
    parameter int MAX_PLANES      = bpargb_pkg::DEF_MAX_PLANES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_operation,
    input  wire logic [4:0]  i_palette_slot,
    input  wire logic [11:0] i_palette_rgb,
    input  wire logic [7:0]  i_plane_byte_a,
    input  wire logic [7:0]  i_plane_byte_b,
    input  wire logic [7:0]  i_plane_byte_c,
    input  wire logic [7:0]  i_plane_byte_d,
    input  wire logic [7:0]  i_plane_byte_e,
    input  wire logic [7:0]  i_mask_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_argb_pixel,
    output logic             o_group_last,
    output logic             o_sprite_last
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    bpargb_pkg::t_cfg      r_cfg;
    bpargb_pkg::t_pal_ctl  w_ctl;
    bpargb_pkg::t_pix      w_rd_pix;
    bpargb_pkg::t_pix      w_out_pix;
    logic [bpargb_pkg::PLANE_INPUTS-1:0][7:0] w_planes;
    logic [AW-1:0]         w_addr;
    logic [31:0]           w_wdata;
    logic                  w_rd_v;
    logic [1:0]            w_cnt;
    logic                  w_pop;
    logic                  w_can_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plane_count <= 3'd1;
            r_cfg.mask_enable <= 1'b0;
            r_cfg.row_bytes   <= 16'd1;
            r_cfg.row_total   <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (bpargb_pkg::t_cfg_idx'(i_cfg_index))
                bpargb_pkg::CFG_PLANE_COUNT: r_cfg.plane_count <= i_cfg_wdata[2:0];
                bpargb_pkg::CFG_MASK_ENABLE: r_cfg.mask_enable <= i_cfg_wdata[0];
                bpargb_pkg::CFG_ROW_BYTES:   r_cfg.row_bytes   <= i_cfg_wdata;
                bpargb_pkg::CFG_ROW_TOTAL:   r_cfg.row_total   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_planes[0] = i_plane_byte_a;
    assign w_planes[1] = i_plane_byte_b;
    assign w_planes[2] = i_plane_byte_c;
    assign w_planes[3] = i_plane_byte_d;
    assign w_planes[4] = i_plane_byte_e;

    // queued plus in-flight pixels never exceed the queue depth
    assign w_pop       = o_out_valid && !i_out_stall;
    assign w_can_issue = ({1'b0, w_cnt} + 3'(w_rd_v) - 3'(w_pop)) < 3'd2;

    bpargb_seq #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_PLANES      (MAX_PLANES)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_palette_slot (i_palette_slot),
        .i_palette_rgb  (i_palette_rgb),
        .i_plane_bytes  (w_planes),
        .i_mask_byte    (i_mask_byte),
        .i_can_issue    (w_can_issue),
        .o_ctl          (w_ctl),
        .o_addr         (w_addr),
        .o_wdata        (w_wdata)
    );

    bpargb_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_valid (w_rd_v),
        .o_pix   (w_rd_pix)
    );

    bpargb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rd_v),
        .i_pix   (w_rd_pix),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_pix   (w_out_pix),
        .o_count (w_cnt)
    );

    assign o_argb_pixel  = w_out_pix.argb;
    assign o_group_last  = w_out_pix.group_last;
    assign o_sprite_last = w_out_pix.sprite_last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, w_cnt} + 3'(w_rd_v)) <= 3'd2)
        else $error("output queue overrun");

    a_sprite_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sprite_last |-> o_group_last)
        else $error("sprite end off a group boundary");

    a_pal_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_operation == bpargb_pkg::OP_PAL_WRITE)
        |=> !o_in_stall)
        else $error("palette write held the input");

    a_no_read_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.wr_en && w_ctl.rd_en))
        else $error("palette read and write in one cycle");

endmodule
`default_nettype wire
